### rtl/core/look_at_view_matrix_core_macros.svh
// assertion macros shared by the view matrix core
`ifndef LOOK_AT_VIEW_MATRIX_CORE_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define LAVM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define LAVM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/lavm_pkg.sv
// shared constants for the view matrix core
`default_nettype none
package lavm_pkg;
	localparam int WORD_W        = 32;
	localparam int FRAC_BITS_DEF = 16;
	// magnitudes are normalized so that the top one sits at this bit
	localparam int NORM_MSB      = 30;
	localparam int CFG_IDX_W     = 2;

	localparam logic [1:0] ROW_U = 2'd0;
	localparam logic [1:0] ROW_V = 2'd1;
	localparam logic [1:0] ROW_W = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_UP_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UP_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UP_Z = 2'd2;
endpackage
`default_nettype wire

### rtl/core/look_at_view_matrix_core.sv
// Look-at view matrix builder. Each transaction on the input channel (eye position and view
// direction, signed fixed point with FRAC_BITS fraction bits) yields three output
// transactions, rows u, v and w in that order, each with its unit axis and offset
// -dot(axis, eye); last marks row w and degenerate marks a zero direction or one parallel
// to the up vector (axes and offsets then read zero). The up vector is written through
// cfg_we/cfg_index/cfg_data and resets to (0, 1.0, 0). The two normalizers dominate the
// latency from input acceptance to the first row, each a 32-stage square root followed by a
// FRAC_BITS+1 stage divider. A new input is taken every cycle while the pipeline moves; the
// pipeline stalls while the single row-wide output port sends rows u and v of a matrix, so
// sustained throughput is set by that port.
`default_nettype none
`include "look_at_view_matrix_core_macros.svh"
module look_at_view_matrix_core #(
	parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [lavm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lavm_pkg::WORD_W-1:0]           cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [lavm_pkg::WORD_W-1:0]    eye_x,
	input  logic signed [lavm_pkg::WORD_W-1:0]    eye_y,
	input  logic signed [lavm_pkg::WORD_W-1:0]    eye_z,
	input  logic signed [lavm_pkg::WORD_W-1:0]    dir_x,
	input  logic signed [lavm_pkg::WORD_W-1:0]    dir_y,
	input  logic signed [lavm_pkg::WORD_W-1:0]    dir_z,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [1:0]                            row,
	output logic signed [FRAC_BITS+1:0]           axis_x,
	output logic signed [FRAC_BITS+1:0]           axis_y,
	output logic signed [FRAC_BITS+1:0]           axis_z,
	output logic signed [lavm_pkg::WORD_W-1:0]    offset,
	output logic                                  last,
	output logic                                  degenerate
);
	localparam int W    = lavm_pkg::WORD_W;
	localparam int A_W  = FRAC_BITS + 2;
	localparam int P_W  = A_W + W;
	localparam int C_W  = P_W + 1;
	localparam int WU_W = 2 * A_W;
	localparam int VD_W = WU_W + 1;
	localparam int D_W  = P_W + 2;
	localparam int RND_W = (VD_W > D_W) ? VD_W : D_W;
	localparam int RO_W = RND_W - FRAC_BITS + 1;
	localparam int E_W  = 3 * W;
	localparam int S2_W = 3 * A_W + E_W;

	localparam logic signed [RO_W-1:0] V_ONE = RO_W'(longint'(1) << FRAC_BITS);
	localparam logic signed [RO_W-1:0] V_MONE = -V_ONE;
	localparam logic signed [RO_W-1:0] O_MAX = RO_W'(32'sh7FFFFFFF);
	localparam logic signed [RO_W-1:0] O_MIN = RO_W'(32'sh80000000);

	// round from 2*FRAC_BITS to FRAC_BITS fraction bits, half away from zero
	function automatic logic signed [RO_W-1:0] rnd_frac(input logic signed [RND_W-1:0] x);
		logic [RND_W-1:0] mag;
		logic [RND_W-1:0] r;
		mag = x[RND_W-1] ? RND_W'(-x) : RND_W'(x);
		r = (mag + (RND_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		rnd_frac = x[RND_W-1] ? -$signed(RO_W'(r)) : $signed(RO_W'(r));
	endfunction

	// up vector registers
	logic signed [W-1:0] up_x_q, up_y_q, up_z_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_x_q <= '0;
			up_y_q <= W'(longint'(1) << FRAC_BITS);
			up_z_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lavm_pkg::REG_UP_X: up_x_q <= cfg_data;
				lavm_pkg::REG_UP_Y: up_y_q <= cfg_data;
				lavm_pkg::REG_UP_Z: up_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// output buffer state and pipeline advance
	logic        ob_valid_q;
	logic [1:0]  row_q;
	logic        en;
	assign en       = !ob_valid_q || (out_ready && row_q == lavm_pkg::ROW_W);
	assign in_ready = en;

	// forward axis
	logic                  w_v, w_ok;
	logic [2:0][A_W-1:0]   w_vec;
	logic [E_W-1:0]        w_eye;
	lavm_unitize #(.IN_W(W), .FRAC_BITS(FRAC_BITS), .SIDE_W(E_W)) u_unit_w (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_valid),
		.in_vec({dir_z, dir_y, dir_x}), .in_side({eye_z, eye_y, eye_x}),
		.out_valid(w_v), .out_ok(w_ok), .out_vec(w_vec), .out_side(w_eye)
	);

	// cross(w, up): products
	logic signed [A_W-1:0] wz_c [3];
	always_comb begin
		for (int i = 0; i < 3; i++) wz_c[i] = w_ok ? $signed(w_vec[i]) : '0;
	end

	logic                  v_s1;
	logic signed [P_W-1:0] pa_s1 [3];
	logic signed [P_W-1:0] pb_s1 [3];
	logic [2:0][A_W-1:0]   w_s1;
	logic [E_W-1:0]        eye_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= w_v;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1[0] <= wz_c[1] * up_z_q;
			pb_s1[0] <= wz_c[2] * up_y_q;
			pa_s1[1] <= wz_c[2] * up_x_q;
			pb_s1[1] <= wz_c[0] * up_z_q;
			pa_s1[2] <= wz_c[0] * up_y_q;
			pb_s1[2] <= wz_c[1] * up_x_q;
			w_s1     <= {wz_c[2], wz_c[1], wz_c[0]};
			eye_s1   <= w_eye;
		end
	end

	// cross(w, up): differences
	logic                  v_s2;
	logic [2:0][C_W-1:0]   c_s2;
	logic [2:0][A_W-1:0]   w_s2;
	logic [E_W-1:0]        eye_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) c_s2[i] <= C_W'(pa_s1[i]) - C_W'(pb_s1[i]);
			w_s2   <= w_s1;
			eye_s2 <= eye_s1;
		end
	end

	// right axis
	logic                  u_v, u_ok;
	logic [2:0][A_W-1:0]   u_vec;
	logic [S2_W-1:0]       u_side;
	lavm_unitize #(.IN_W(C_W), .FRAC_BITS(FRAC_BITS), .SIDE_W(S2_W)) u_unit_u (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s2),
		.in_vec(c_s2), .in_side({w_s2, eye_s2}),
		.out_valid(u_v), .out_ok(u_ok), .out_vec(u_vec), .out_side(u_side)
	);

	logic [2:0][A_W-1:0] w_u;
	logic [E_W-1:0]      eye_u;
	assign {w_u, eye_u} = u_side;

	// cross(w, u): products
	logic                   v_s3, ok_s3;
	logic signed [WU_W-1:0] qa_s3 [3];
	logic signed [WU_W-1:0] qb_s3 [3];
	logic [2:0][A_W-1:0]    u_s3, w_s3;
	logic [E_W-1:0]         eye_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= u_v;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			qa_s3[0] <= $signed(w_u[1]) * $signed(u_vec[2]);
			qb_s3[0] <= $signed(w_u[2]) * $signed(u_vec[1]);
			qa_s3[1] <= $signed(w_u[2]) * $signed(u_vec[0]);
			qb_s3[1] <= $signed(w_u[0]) * $signed(u_vec[2]);
			qa_s3[2] <= $signed(w_u[0]) * $signed(u_vec[1]);
			qb_s3[2] <= $signed(w_u[1]) * $signed(u_vec[0]);
			ok_s3    <= u_ok;
			u_s3     <= u_vec;
			w_s3     <= w_u;
			eye_s3   <= eye_u;
		end
	end

	// cross(w, u): differences
	logic                   v_s4, ok_s4;
	logic signed [VD_W-1:0] vd_s4 [3];
	logic [2:0][A_W-1:0]    u_s4, w_s4;
	logic [E_W-1:0]         eye_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) vd_s4[i] <= VD_W'(qa_s3[i]) - VD_W'(qb_s3[i]);
			ok_s4  <= ok_s3;
			u_s4   <= u_s3;
			w_s4   <= w_s3;
			eye_s4 <= eye_s3;
		end
	end

	// v: round and clamp to +-1.0
	logic signed [RO_W-1:0] vr_c [3];
	logic [2:0][A_W-1:0]    vc_c;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vr_c[i] = rnd_frac(RND_W'(vd_s4[i]));
			if (vr_c[i] > V_ONE) vc_c[i] = A_W'(V_ONE);
			else if (vr_c[i] < V_MONE) vc_c[i] = A_W'(V_MONE);
			else vc_c[i] = A_W'(vr_c[i]);
		end
	end

	logic                       v_s5, ok_s5;
	logic [2:0][2:0][A_W-1:0]   ax_s5;
	logic [E_W-1:0]             eye_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s5[lavm_pkg::ROW_U] <= u_s4;
			ax_s5[lavm_pkg::ROW_V] <= vc_c;
			ax_s5[lavm_pkg::ROW_W] <= w_s4;
			ok_s5  <= ok_s4;
			eye_s5 <= eye_s4;
		end
	end

	// offsets: axis times eye products
	logic [2:0][W-1:0] eye5;
	assign eye5 = eye_s5;

	logic                       v_s6, ok_s6;
	logic signed [P_W-1:0]      dp_s6 [3][3];
	logic [2:0][2:0][A_W-1:0]   ax_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int i = 0; i < 3; i++) begin
					dp_s6[r][i] <= $signed(ax_s5[r][i]) * $signed(eye5[i]);
				end
			end
			ok_s6 <= ok_s5;
			ax_s6 <= ax_s5;
		end
	end

	// offsets: dot product sums
	logic                       v_s7, ok_s7;
	logic signed [D_W-1:0]      ds_s7 [3];
	logic [2:0][2:0][A_W-1:0]   ax_s7;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (en) v_s7 <= v_s6;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				ds_s7[r] <= D_W'(dp_s6[r][0]) + D_W'(dp_s6[r][1]) + D_W'(dp_s6[r][2]);
			end
			ok_s7 <= ok_s6;
			ax_s7 <= ax_s6;
		end
	end

	// offsets: round, negate, saturate; zero everything on a degenerate frame
	logic signed [RO_W-1:0] on_c [3];
	logic [2:0][W-1:0]      off_c;
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			on_c[r] = -rnd_frac(RND_W'(ds_s7[r]));
			if (on_c[r] > O_MAX) off_c[r] = W'(O_MAX);
			else if (on_c[r] < O_MIN) off_c[r] = W'(O_MIN);
			else off_c[r] = W'(on_c[r]);
		end
	end

	logic                       v_s8, deg_s8;
	logic [2:0][2:0][A_W-1:0]   ax_s8;
	logic [2:0][W-1:0]          off_s8;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else if (en) v_s8 <= v_s7;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s8  <= ok_s7 ? ax_s7 : '0;
			off_s8 <= ok_s7 ? off_c : '0;
			deg_s8 <= !ok_s7;
		end
	end

	// output buffer: holds one matrix and sends its rows in order
	logic [2:0][2:0][A_W-1:0] ob_ax_q;
	logic [2:0][W-1:0]        ob_off_q;
	logic                     ob_deg_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_valid_q <= 1'b0;
			row_q      <= lavm_pkg::ROW_U;
		end else if (en) begin
			ob_valid_q <= v_s8;
			row_q      <= lavm_pkg::ROW_U;
		end else if (out_ready) begin
			row_q <= row_q + 2'd1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ob_ax_q  <= ax_s8;
			ob_off_q <= off_s8;
			ob_deg_q <= deg_s8;
		end
	end

	assign out_valid  = ob_valid_q;
	assign row        = row_q;
	assign axis_x     = ob_ax_q[row_q][0];
	assign axis_y     = ob_ax_q[row_q][1];
	assign axis_z     = ob_ax_q[row_q][2];
	assign offset     = ob_off_q[row_q];
	assign last       = row_q == lavm_pkg::ROW_W;
	assign degenerate = ob_deg_q;

	// checks
	`LAVM_ASSERT_IMP(a_deg_zero, out_valid && degenerate,
		axis_x == '0 && axis_y == '0 && axis_z == '0 && offset == '0,
		"degenerate row carries nonzero data")
	`LAVM_ASSERT_NXT(a_row_step, out_valid && out_ready && row != lavm_pkg::ROW_W,
		out_valid && row == $past(row) + 2'd1, "row sequence broken")
	`LAVM_ASSERT_IMP(a_no_overrun, in_ready && out_valid,
		out_ready && last, "pipeline advanced over an unfinished matrix")
endmodule
`default_nettype wire

### rtl/core/lavm_unitize.sv
// pipelined unit-length scaling of a three component vector
`default_nettype none
module lavm_unitize #(
	parameter int IN_W      = 32,
	parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF,
	parameter int SIDE_W    = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [2:0][IN_W-1:0]          in_vec,
	input  logic [SIDE_W-1:0]             in_side,
	output logic                          out_valid,
	output logic                          out_ok,
	output logic [2:0][FRAC_BITS+1:0]     out_vec,
	output logic [SIDE_W-1:0]             out_side
);
	localparam int POS_W  = $clog2(IN_W);
	localparam int M_W    = lavm_pkg::NORM_MSB + 1;
	localparam int SQ_W   = 2 * M_W;
	localparam int S_W    = SQ_W + 2;
	localparam int ROOT_W = S_W / 2;
	localparam int REM_W  = ROOT_W + 3;
	localparam int NUM_W  = M_W + FRAC_BITS + 1;
	localparam int DREM_W = ROOT_W + 1;
	localparam int Q_W    = FRAC_BITS + 1;
	localparam int A_W    = FRAC_BITS + 2;

	typedef struct packed {
		logic [SIDE_W-1:0]     side;
		logic                  ok;
		logic [2:0]            neg;
		logic [2:0][M_W-1:0]   m;
	} car_t;

	typedef struct packed {
		logic [SIDE_W-1:0]     side;
		logic                  ok;
		logic [2:0]            neg;
	} dcar_t;

	// stage 1: magnitudes and their or
	logic [2:0][IN_W-1:0] mag_c;
	logic [IN_W-1:0]      or_c;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = in_vec[i][IN_W-1] ? (~in_vec[i] + IN_W'(1)) : in_vec[i];
		end
		or_c = mag_c[0] | mag_c[1] | mag_c[2];
	end

	logic                 v_s1;
	logic [2:0][IN_W-1:0] mag_s1;
	logic [2:0]           neg_s1;
	logic [IN_W-1:0]      or_s1;
	logic [SIDE_W-1:0]    side_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= mag_c;
			neg_s1  <= {in_vec[2][IN_W-1], in_vec[1][IN_W-1], in_vec[0][IN_W-1]};
			or_s1   <= or_c;
			side_s1 <= in_side;
		end
	end

	// stage 2: position of the leading one
	logic [POS_W-1:0] pos_c;
	always_comb begin
		pos_c = '0;
		for (int b = 0; b < IN_W; b++) begin
			if (or_s1[b]) pos_c = POS_W'(b);
		end
	end

	logic                 v_s2;
	logic [2:0][IN_W-1:0] mag_s2;
	logic [2:0]           neg_s2;
	logic [POS_W-1:0]     pos_s2;
	logic                 nz_s2;
	logic [SIDE_W-1:0]    side_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			pos_s2  <= pos_c;
			nz_s2   <= |or_s1;
			side_s2 <= side_s1;
		end
	end

	// stage 3: shift all components together to the normalized range
	localparam logic [POS_W:0] NM = (POS_W+1)'(lavm_pkg::NORM_MSB);
	logic [POS_W:0]      pos_e;
	logic [POS_W:0]      amt_c;
	logic [2:0][M_W-1:0] nrm_c;
	always_comb begin
		pos_e = {1'b0, pos_s2};
		amt_c = (pos_e > NM) ? (pos_e - NM) : (NM - pos_e);
		for (int i = 0; i < 3; i++) begin
			if (pos_e > NM) nrm_c[i] = M_W'(mag_s2[i] >> amt_c);
			else nrm_c[i] = M_W'(mag_s2[i] << amt_c);
		end
	end

	logic                v_s3;
	car_t                car_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			car_s3.m    <= nrm_c;
			car_s3.neg  <= neg_s2;
			car_s3.ok   <= nz_s2;
			car_s3.side <= side_s2;
		end
	end

	// stage 4: squares
	logic                 v_s4;
	logic [2:0][SQ_W-1:0] sq_s4;
	car_t                 car_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) sq_s4[i] <= car_s3.m[i] * car_s3.m[i];
			car_s4 <= car_s3;
		end
	end

	// stage 5: sum of squares
	logic            v_s5;
	logic [S_W-1:0]  sum_s5;
	car_t            car_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s5 <= S_W'(sq_s4[0]) + S_W'(sq_s4[1]) + S_W'(sq_s4[2]);
			car_s5 <= car_s4;
		end
	end

	// square root, one result bit per stage
	logic              sq_v    [0:ROOT_W];
	logic [S_W-1:0]    sq_s    [0:ROOT_W];
	logic [REM_W-1:0]  sq_rem  [0:ROOT_W];
	logic [ROOT_W-1:0] sq_root [0:ROOT_W];
	car_t              sq_car  [0:ROOT_W];

	assign sq_v[0]    = v_s5;
	assign sq_s[0]    = sum_s5;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_car[0]  = car_s5;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		logic [REM_W-1:0] rn;
		logic [REM_W-1:0] tr;
		assign rn = {sq_rem[k][REM_W-3:0], sq_s[k][S_W-1 -: 2]};
		assign tr = {1'b0, sq_root[k], 2'b01};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v[k+1] <= 1'b0;
			else if (en) sq_v[k+1] <= sq_v[k];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (rn >= tr) begin
					sq_rem[k+1]  <= rn - tr;
					sq_root[k+1] <= {sq_root[k][ROOT_W-2:0], 1'b1};
				end else begin
					sq_rem[k+1]  <= rn;
					sq_root[k+1] <= {sq_root[k][ROOT_W-2:0], 1'b0};
				end
				sq_s[k+1]   <= sq_s[k] << 2;
				sq_car[k+1] <= sq_car[k];
			end
		end
	end

	// division setup: numerator with half the divisor added for rounding
	logic                   dv_v    [0:Q_W];
	logic [ROOT_W-1:0]      dv_n    [0:Q_W];
	logic [2:0][NUM_W-1:0]  dv_num  [0:Q_W];
	logic [2:0][DREM_W-1:0] dv_rem  [0:Q_W];
	logic [2:0][Q_W-1:0]    dv_q    [0:Q_W];
	dcar_t                  dv_car  [0:Q_W];

	logic [2:0][NUM_W-1:0] num_c;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num_c[i] = NUM_W'({sq_car[ROOT_W].m[i], {FRAC_BITS{1'b0}}})
				+ NUM_W'(sq_root[ROOT_W] >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_v[0] <= 1'b0;
		else if (en) dv_v[0] <= sq_v[ROOT_W];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			dv_n[0]   <= sq_root[ROOT_W];
			dv_num[0] <= num_c;
			for (int i = 0; i < 3; i++) dv_rem[0][i] <= DREM_W'(num_c[i] >> Q_W);
			dv_q[0]   <= '0;
			dv_car[0] <= '{side: sq_car[ROOT_W].side, ok: sq_car[ROOT_W].ok,
				neg: sq_car[ROOT_W].neg};
		end
	end

	// restoring division, one quotient bit per stage for all three components
	for (genvar j = 0; j < Q_W; j++) begin : g_div
		logic [2:0][DREM_W-1:0] rn;
		logic [2:0]             ge;
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				rn[i] = {dv_rem[j][i][DREM_W-2:0], dv_num[j][i][FRAC_BITS-j]};
				ge[i] = rn[i] >= {1'b0, dv_n[j]};
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v[j+1] <= 1'b0;
			else if (en) dv_v[j+1] <= dv_v[j];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					dv_rem[j+1][i] <= ge[i] ? (rn[i] - {1'b0, dv_n[j]}) : rn[i];
					dv_q[j+1][i]   <= {dv_q[j][i][Q_W-2:0], ge[i]};
				end
				dv_n[j+1]   <= dv_n[j];
				dv_num[j+1] <= dv_num[j];
				dv_car[j+1] <= dv_car[j];
			end
		end
	end

	// final stage: restore signs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= dv_v[Q_W];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				out_vec[i] <= dv_car[Q_W].neg[i] ? (A_W'(0) - {1'b0, dv_q[Q_W][i]})
					: {1'b0, dv_q[Q_W][i]};
			end
			out_ok   <= dv_car[Q_W].ok;
			out_side <= dv_car[Q_W].side;
		end
	end
endmodule
`default_nettype wire
